>>> rtl/bti_pkg.sv
// shared constants, codes and types for the bilinear table interpolator
package bti_pkg;

    localparam int NUM_TABLES = 4;
    localparam int MAX_POINTS = 16;
    localparam int DATA_W     = 32;
    localparam int TID_W      = 2;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 5;
    localparam int OP_W       = 3;
    localparam int ST_W       = 3;
    localparam int BP_AW      = TID_W + IDX_W;
    localparam int C_AW       = TID_W + 2 * IDX_W;
    localparam int S_TDATA_W  = 120;
    localparam int M_TDATA_W  = 32;

    localparam logic [OP_W-1:0] OP_WR_X   = 3'd0;
    localparam logic [OP_W-1:0] OP_WR_Y   = 3'd1;
    localparam logic [OP_W-1:0] OP_WR_Z   = 3'd2;
    localparam logic [OP_W-1:0] OP_COMMIT = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_NOT_COMM = 3'd1;
    localparam logic [ST_W-1:0] ST_X_RANGE  = 3'd2;
    localparam logic [ST_W-1:0] ST_Y_RANGE  = 3'd3;
    localparam logic [ST_W-1:0] ST_KEY_USED = 3'd4;
    localparam logic [ST_W-1:0] ST_BAD_SIZE = 3'd5;

    typedef enum logic [4:0] {
        S_IDLE, S_EXEC, S_XR0, S_XR1, S_XR2, S_YR0, S_YR1, S_YR2,
        S_XS_A, S_XS_D, S_YS_A, S_YS_D, S_C0, S_C1, S_C2, S_C3, S_C4,
        S_L0G, S_L0W, S_L1G, S_L1W, S_L2G, S_L2W, S_EMIT
    } t_state;

    typedef enum logic [4:0] {
        DP_IDLE, DP_LOAD, DP_EXEC, DP_XR0, DP_XR1, DP_XR2, DP_YR0, DP_YR1, DP_YR2,
        DP_XS_A, DP_XS_D, DP_YS_A, DP_YS_D, DP_C0, DP_C1, DP_C2, DP_C3, DP_C4,
        DP_L0G, DP_L0W, DP_L1G, DP_L1W, DP_L2G, DP_L2W, DP_EMIT
    } t_dp_cmd;

    typedef struct packed {
        logic query_go;
        logic range_bad;
        logic scan_done;
        logic lerp_done;
        logic out_busy;
    } t_dp_sts;

    typedef enum logic [2:0] {
        L_IDLE, L_MUL, L_DIV, L_FIN, L_DONE
    } t_lstate;

endpackage

>>> rtl/bti_lerp.sv
// serial linear interpolation unit: shift-add multiply then restoring divide
module bti_lerp
    import bti_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DATA_W-1:0] i_za,
    input  logic signed [DATA_W-1:0] i_zb,
    input  logic signed [DATA_W-1:0] i_a,
    input  logic signed [DATA_W-1:0] i_b,
    input  logic signed [DATA_W-1:0] i_q,
    output logic                     o_done,
    output logic signed [DATA_W-1:0] o_result
);

    t_lstate r_state, n_state;
    logic [5:0]               r_cnt;
    logic [2*DATA_W+1:0]      r_p;
    logic [DATA_W:0]          r_mag;
    logic [DATA_W-1:0]        r_w;
    logic                     r_neg;
    logic signed [DATA_W-1:0] r_za;
    logic signed [DATA_W-1:0] r_res;

    logic signed [DATA_W:0] w_w, w_t, w_d, w_tc;
    logic [DATA_W:0]        w_mag;
    logic [DATA_W+1:0]      w_hi;
    logic [DATA_W:0]        w_trial;
    logic                   w_ge;
    logic [DATA_W-1:0]      w_rem;
    logic signed [DATA_W+2:0] w_sum;

    assign w_w = {i_b[DATA_W-1], i_b} - {i_a[DATA_W-1], i_a};
    assign w_t = {i_q[DATA_W-1], i_q} - {i_a[DATA_W-1], i_a};
    assign w_d = {i_zb[DATA_W-1], i_zb} - {i_za[DATA_W-1], i_za};
    assign w_mag = w_d[DATA_W] ? DATA_W'(0) - w_d : w_d;

    always_comb begin
        if (w_t < 0) begin
            w_tc = '0;
        end else if (w_t > w_w) begin
            w_tc = w_w;
        end else begin
            w_tc = w_t;
        end
    end

    assign w_hi    = r_p[2*DATA_W+1:DATA_W] + (r_p[0] ? {1'b0, r_mag} : '0);
    assign w_trial = {r_p[2*DATA_W:DATA_W+1], r_p[DATA_W]};
    assign w_ge    = w_trial >= {1'b0, r_w};
    assign w_rem   = w_ge ? DATA_W'(w_trial - {1'b0, r_w}) : w_trial[DATA_W-1:0];
    assign w_sum   = r_neg ? {{3{r_za[DATA_W-1]}}, r_za} - {2'b0, r_p[DATA_W:0]}
                           : {{3{r_za[DATA_W-1]}}, r_za} + {2'b0, r_p[DATA_W:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            L_IDLE: if (i_start) n_state = (w_w <= 0) ? L_DONE : L_MUL;
            L_MUL:  if (r_cnt == 6'd31) n_state = L_DIV;
            L_DIV:  if (r_cnt == 6'd32) n_state = L_FIN;
            L_FIN:  n_state = L_DONE;
            L_DONE: n_state = L_IDLE;
            default: n_state = L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            L_IDLE: begin
                r_cnt <= '0;
                r_za  <= i_za;
                r_res <= i_za;
                r_neg <= w_d[DATA_W];
                r_mag <= w_mag;
                r_w   <= w_w[DATA_W-1:0];
                r_p   <= {{(DATA_W+2){1'b0}}, w_tc[DATA_W-1:0]};
            end
            L_MUL: begin
                r_p   <= {1'b0, w_hi, r_p[DATA_W-1:1]};
                r_cnt <= (r_cnt == 6'd31) ? 6'd0 : r_cnt + 6'd1;
            end
            L_DIV: begin
                r_p   <= {1'b0, w_rem, r_p[DATA_W-1:0], w_ge};
                r_cnt <= r_cnt + 6'd1;
            end
            L_FIN: begin
                if (w_sum > 35'sh7FFFFFFF) begin
                    r_res <= 32'sh7FFFFFFF;
                end else if (w_sum < -35'sh80000000) begin
                    r_res <= 32'sh80000000;
                end else begin
                    r_res <= w_sum[DATA_W-1:0];
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    assign o_done   = (r_state == L_DONE);
    assign o_result = r_res;

endmodule

>>> rtl/bti_dp.sv
// datapath: item registers, table stores, search registers, the interpolator and output register
module bti_dp
    import bti_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    input  logic [S_TDATA_W-1:0] i_tdata,
    input  logic [OP_W-1:0]      i_op,
    input  logic                 i_m_tready,
    output t_dp_sts              o_sts,
    output logic                 o_m_tvalid,
    output logic [M_TDATA_W-1:0] o_m_tdata,
    output logic [ST_W-1:0]      o_m_tuser
);

    logic [DATA_W-1:0] x_mem [2**BP_AW];
    logic [DATA_W-1:0] y_mem [2**BP_AW];
    logic [DATA_W-1:0] c_mem [2**C_AW];

    logic [OP_W-1:0]   r_op;
    logic [TID_W-1:0]  r_tid;
    logic [IDX_W-1:0]  r_col, r_row;
    logic signed [DATA_W-1:0] r_data, r_qx, r_qy;
    logic [CNT_W-1:0]  r_ncol, r_nrow;

    logic              r_valid [NUM_TABLES];
    logic [CNT_W-1:0]  r_cols  [NUM_TABLES];
    logic [CNT_W-1:0]  r_rows  [NUM_TABLES];

    logic signed [DATA_W-1:0] r_xq, r_yq, r_cq, r_prev;
    logic signed [DATA_W-1:0] r_xa, r_xb, r_ya, r_yb;
    logic signed [DATA_W-1:0] r_z00, r_z01, r_z10, r_z11, r_lo, r_hi, r_res;
    logic [IDX_W-1:0]  r_k, r_ix, r_iy;
    logic [ST_W-1:0]   r_status;
    logic              r_ovalid;
    logic [ST_W-1:0]   r_ostatus;
    logic [DATA_W-1:0] r_ores;

    logic [CNT_W-1:0]  w_nc, w_nr;
    logic [IDX_W-1:0]  w_ncm1, w_nrm1, w_ix1, w_iy1;
    logic              w_tval, w_counts_ok, w_xbad, w_ybad, w_xdone, w_ydone;
    logic [BP_AW-1:0]  w_xa, w_ya;
    logic [C_AW-1:0]   w_ca;
    logic              w_lstart, w_ldone;
    logic signed [DATA_W-1:0] w_lza, w_lzb, w_la, w_lb, w_lq, w_lres;

    assign w_nc   = r_cols[r_tid];
    assign w_nr   = r_rows[r_tid];
    assign w_tval = r_valid[r_tid];
    assign w_ncm1 = IDX_W'(w_nc - CNT_W'(1));
    assign w_nrm1 = IDX_W'(w_nr - CNT_W'(1));
    assign w_ix1  = r_ix + IDX_W'(1);
    assign w_iy1  = r_iy + IDX_W'(1);
    assign w_counts_ok = (w_nc >= CNT_W'(2)) && (w_nr >= CNT_W'(2)) &&
                         (w_nc <= CNT_W'(MAX_POINTS)) && (w_nr <= CNT_W'(MAX_POINTS));

    assign w_xbad  = (r_qx < r_prev) || (r_qx > r_xq);
    assign w_ybad  = (r_qy < r_prev) || (r_qy > r_yq);
    assign w_xdone = ((r_k != '0) && (r_prev <= r_qx) && (r_qx <= r_xq)) || (r_k == w_ncm1);
    assign w_ydone = ((r_k != '0) && (r_prev <= r_qy) && (r_qy <= r_yq)) || (r_k == w_nrm1);

    always_comb begin
        w_xa = {r_tid, r_k};
        w_ya = {r_tid, r_k};
        w_ca = {r_tid, r_iy, r_ix};
        case (i_cmd)
            DP_XR0: w_xa = {r_tid, {IDX_W{1'b0}}};
            DP_XR1: w_xa = {r_tid, w_ncm1};
            DP_YR0: w_ya = {r_tid, {IDX_W{1'b0}}};
            DP_YR1: w_ya = {r_tid, w_nrm1};
            DP_C1:  w_ca = {r_tid, r_iy, w_ix1};
            DP_C2:  w_ca = {r_tid, w_iy1, r_ix};
            DP_C3:  w_ca = {r_tid, w_iy1, w_ix1};
            default: w_ca = {r_tid, r_iy, r_ix};
        endcase
    end

    always_comb begin
        w_lstart = 1'b0;
        w_lza = r_z00;
        w_lzb = r_z01;
        w_la  = r_xa;
        w_lb  = r_xb;
        w_lq  = r_qx;
        case (i_cmd)
            DP_L0G: w_lstart = 1'b1;
            DP_L1G: begin
                w_lstart = 1'b1;
                w_lza = r_z10;
                w_lzb = r_z11;
            end
            DP_L2G: begin
                w_lstart = 1'b1;
                w_lza = r_lo;
                w_lzb = r_hi;
                w_la  = r_ya;
                w_lb  = r_yb;
                w_lq  = r_qy;
            end
            default: w_lstart = 1'b0;
        endcase
    end

    bti_lerp u_lerp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_lstart),
        .i_za     (w_lza),
        .i_zb     (w_lzb),
        .i_a      (w_la),
        .i_b      (w_lb),
        .i_q      (w_lq),
        .o_done   (w_ldone),
        .o_result (w_lres)
    );

    // table stores
    always_ff @(posedge i_clk) begin
        if (i_cmd == DP_EXEC) begin
            if (r_op == OP_WR_X) x_mem[{r_tid, r_col}] <= r_data;
            if (r_op == OP_WR_Y) y_mem[{r_tid, r_row}] <= r_data;
            if (r_op == OP_WR_Z) c_mem[{r_tid, r_row, r_col}] <= r_data;
        end
        r_xq <= x_mem[w_xa];
        r_yq <= y_mem[w_ya];
        r_cq <= c_mem[w_ca];
    end

    // table descriptors
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TABLES; i++) begin
                r_valid[i] <= 1'b0;
                r_cols[i]  <= '0;
                r_rows[i]  <= '0;
            end
        end else if (i_cmd == DP_EXEC && r_op == OP_COMMIT && !w_tval &&
                     r_ncol >= CNT_W'(2) && r_nrow >= CNT_W'(2) &&
                     r_ncol <= CNT_W'(MAX_POINTS) && r_nrow <= CNT_W'(MAX_POINTS)) begin
            r_valid[r_tid] <= 1'b1;
            r_cols[r_tid]  <= r_ncol;
            r_rows[r_tid]  <= r_nrow;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            DP_LOAD: begin
                r_op   <= i_op;
                r_tid  <= i_tdata[1:0];
                r_col  <= i_tdata[5:2];
                r_row  <= i_tdata[9:6];
                r_data <= i_tdata[41:10];
                r_qx   <= i_tdata[73:42];
                r_qy   <= i_tdata[105:74];
                r_ncol <= i_tdata[110:106];
                r_nrow <= i_tdata[115:111];
            end
            DP_EXEC: begin
                r_res <= '0;
                case (r_op)
                    OP_COMMIT: begin
                        if (w_tval) begin
                            r_status <= ST_KEY_USED;
                        end else if (r_ncol < CNT_W'(2) || r_nrow < CNT_W'(2) ||
                                     r_ncol > CNT_W'(MAX_POINTS) ||
                                     r_nrow > CNT_W'(MAX_POINTS)) begin
                            r_status <= ST_BAD_SIZE;
                        end else begin
                            r_status <= ST_OK;
                        end
                    end
                    OP_QUERY: begin
                        if (!w_tval || !w_counts_ok) begin
                            r_status <= ST_NOT_COMM;
                        end else begin
                            r_status <= ST_OK;
                        end
                    end
                    default: r_status <= ST_OK;
                endcase
            end
            DP_XR1: r_prev <= r_xq;
            DP_XR2: if (w_xbad) r_status <= ST_X_RANGE;
            DP_YR1: r_prev <= r_yq;
            DP_YR2: begin
                if (w_ybad) r_status <= ST_Y_RANGE;
                r_k <= '0;
            end
            DP_XS_D: begin
                r_prev <= r_xq;
                if (w_xdone) begin
                    r_ix <= r_k - IDX_W'(1);
                    r_xa <= r_prev;
                    r_xb <= r_xq;
                    r_k  <= '0;
                end else begin
                    r_k <= r_k + IDX_W'(1);
                end
            end
            DP_YS_D: begin
                r_prev <= r_yq;
                if (w_ydone) begin
                    r_iy <= r_k - IDX_W'(1);
                    r_ya <= r_prev;
                    r_yb <= r_yq;
                end else begin
                    r_k <= r_k + IDX_W'(1);
                end
            end
            DP_C1: r_z00 <= r_cq;
            DP_C2: r_z01 <= r_cq;
            DP_C3: r_z10 <= r_cq;
            DP_C4: r_z11 <= r_cq;
            DP_L0W: if (w_ldone) r_lo <= w_lres;
            DP_L1W: if (w_ldone) r_hi <= w_lres;
            DP_L2W: if (w_ldone) r_res <= w_lres;
            default: r_k <= r_k;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd == DP_EMIT) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == DP_EMIT) begin
            r_ostatus <= r_status;
            r_ores    <= r_res;
        end
    end

    always_comb begin
        o_sts.query_go  = (r_op == OP_QUERY) && w_tval && w_counts_ok;
        o_sts.range_bad = (i_cmd == DP_XR2) ? w_xbad : w_ybad;
        o_sts.scan_done = (i_cmd == DP_XS_D) ? w_xdone : w_ydone;
        o_sts.lerp_done = w_ldone;
        o_sts.out_busy  = r_ovalid && !i_m_tready;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_ores;
    assign o_m_tuser  = r_ostatus;

endmodule

>>> rtl/bti_ctrl.sv
// controller state machine sequencing one transaction through the datapath
module bti_ctrl
    import bti_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    input  t_dp_sts i_sts,
    output logic    o_s_tready,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = DP_IDLE;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd   = DP_LOAD;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd   = DP_EXEC;
                n_state = i_sts.query_go ? S_XR0 : S_EMIT;
            end
            S_XR0: begin
                o_cmd   = DP_XR0;
                n_state = S_XR1;
            end
            S_XR1: begin
                o_cmd   = DP_XR1;
                n_state = S_XR2;
            end
            S_XR2: begin
                o_cmd   = DP_XR2;
                n_state = i_sts.range_bad ? S_EMIT : S_YR0;
            end
            S_YR0: begin
                o_cmd   = DP_YR0;
                n_state = S_YR1;
            end
            S_YR1: begin
                o_cmd   = DP_YR1;
                n_state = S_YR2;
            end
            S_YR2: begin
                o_cmd   = DP_YR2;
                n_state = i_sts.range_bad ? S_EMIT : S_XS_A;
            end
            S_XS_A: begin
                o_cmd   = DP_XS_A;
                n_state = S_XS_D;
            end
            S_XS_D: begin
                o_cmd   = DP_XS_D;
                n_state = i_sts.scan_done ? S_YS_A : S_XS_A;
            end
            S_YS_A: begin
                o_cmd   = DP_YS_A;
                n_state = S_YS_D;
            end
            S_YS_D: begin
                o_cmd   = DP_YS_D;
                n_state = i_sts.scan_done ? S_C0 : S_YS_A;
            end
            S_C0: begin
                o_cmd   = DP_C0;
                n_state = S_C1;
            end
            S_C1: begin
                o_cmd   = DP_C1;
                n_state = S_C2;
            end
            S_C2: begin
                o_cmd   = DP_C2;
                n_state = S_C3;
            end
            S_C3: begin
                o_cmd   = DP_C3;
                n_state = S_C4;
            end
            S_C4: begin
                o_cmd   = DP_C4;
                n_state = S_L0G;
            end
            S_L0G: begin
                o_cmd   = DP_L0G;
                n_state = S_L0W;
            end
            S_L0W: begin
                o_cmd = DP_L0W;
                if (i_sts.lerp_done) n_state = S_L1G;
            end
            S_L1G: begin
                o_cmd   = DP_L1G;
                n_state = S_L1W;
            end
            S_L1W: begin
                o_cmd = DP_L1W;
                if (i_sts.lerp_done) n_state = S_L2G;
            end
            S_L2G: begin
                o_cmd   = DP_L2G;
                n_state = S_L2W;
            end
            S_L2W: begin
                o_cmd = DP_L2W;
                if (i_sts.lerp_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd   = DP_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

>>> rtl/bilinear_table_interp.sv
// top level of the keyed 2d lookup table with bilinear interpolation
// writes, commits, unused ops, uncommitted queries: result loads after the execute state
// range rejects stop after the x or y range check; full queries also scan and interpolate
// the serial interpolator does 32 multiply and 33 divide steps a run, three runs a query
// one transaction in flight; next accept can come the cycle after the result register loads
// synchronous active-low reset clears control and table descriptors, stores are left as is
module bilinear_table_interp
    import bti_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // table_id, col_index, row_index, data_value, query_x, query_y, col_count, row_count
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // op
    input  logic [OP_W-1:0]      s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // result_value
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // status
    output logic [ST_W-1:0]      m_axis_tuser
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    bti_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_sts      (w_sts),
        .o_s_tready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    bti_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_tdata    (s_axis_tdata),
        .i_op       (s_axis_tuser),
        .i_m_tready (m_axis_tready),
        .o_sts      (w_sts),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser)
    );

endmodule

>>> dv/testbench.sv
// self-checking testbench for the bilinear table interpolator
module testbench;
    import bti_pkg::*;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [TID_W-1:0]  tid;
        logic [IDX_W-1:0]  col;
        logic [IDX_W-1:0]  row;
        logic [31:0]       data;
        logic [31:0]       qx;
        logic [31:0]       qy;
        logic [CNT_W-1:0]  ncol;
        logic [CNT_W-1:0]  nrow;
    } t_cmd;

    typedef struct {
        logic [ST_W-1:0] status;
        logic [31:0]     value;
    } t_res;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [OP_W-1:0]      s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [ST_W-1:0]      m_axis_tuser;

    bilinear_table_interp dut (.*);

    t_cmd   pending_cmds[$];
    t_res   expected_results[$];
    int     error_count = 0;
    int     cycle_count = 0;
    int     hold_cycles = 0;
    bit     in_accepted = 0;
    bit     stim_done   = 0;

    // predictor state
    longint mdl_x[NUM_TABLES][MAX_POINTS];
    longint mdl_y[NUM_TABLES][MAX_POINTS];
    longint mdl_z[NUM_TABLES][MAX_POINTS][MAX_POINTS];
    bit     mdl_valid[NUM_TABLES];
    int     mdl_cols[NUM_TABLES];
    int     mdl_rows[NUM_TABLES];

    // stimulus-side view of the tables
    longint gen_x[NUM_TABLES][MAX_POINTS];
    longint gen_y[NUM_TABLES][MAX_POINTS];
    int     gen_cols[NUM_TABLES];
    int     gen_rows[NUM_TABLES];

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint lerp_axis(longint za, longint zb, longint a, longint b,
                                         longint q);
        longint w, t, d;
        longint unsigned mag, part;
        w = b - a;
        t = q - a;
        d = zb - za;
        if (w <= 0) return sat32(za);
        if (t < 0) t = 0;
        if (t > w) t = w;
        mag  = (d < 0) ? -d : d;
        part = (mag * longint'(t)) / longint'(w);
        if (d < 0) return sat32(za - longint'(part));
        return sat32(za + longint'(part));
    endfunction

    function automatic int bracket_x(int tb, int n, longint q);
        for (int i = 0; i + 1 < n; i++)
            if (mdl_x[tb][i] <= q && q <= mdl_x[tb][i+1]) return i;
        return n - 2;
    endfunction

    function automatic int bracket_y(int tb, int n, longint q);
        for (int i = 0; i + 1 < n; i++)
            if (mdl_y[tb][i] <= q && q <= mdl_y[tb][i+1]) return i;
        return n - 2;
    endfunction

    function automatic t_res apply_cmd(t_cmd c);
        t_res   r;
        int     tb, nc, nr, ix, iy;
        longint qx, qy, lo, hi;
        r.status = ST_OK;
        r.value  = '0;
        tb = c.tid;
        qx = longint'($signed(c.qx));
        qy = longint'($signed(c.qy));
        case (c.op)
            OP_WR_X: mdl_x[tb][c.col] = longint'($signed(c.data));
            OP_WR_Y: mdl_y[tb][c.row] = longint'($signed(c.data));
            OP_WR_Z: mdl_z[tb][c.row][c.col] = longint'($signed(c.data));
            OP_COMMIT: begin
                if (mdl_valid[tb]) r.status = ST_KEY_USED;
                else if (c.ncol < 2 || c.nrow < 2 || c.ncol > MAX_POINTS ||
                         c.nrow > MAX_POINTS) r.status = ST_BAD_SIZE;
                else begin
                    mdl_valid[tb] = 1;
                    mdl_cols[tb]  = c.ncol;
                    mdl_rows[tb]  = c.nrow;
                end
            end
            OP_QUERY: begin
                nc = mdl_cols[tb];
                nr = mdl_rows[tb];
                if (!mdl_valid[tb]) r.status = ST_NOT_COMM;
                else if (qx < mdl_x[tb][0] || qx > mdl_x[tb][nc-1]) r.status = ST_X_RANGE;
                else if (qy < mdl_y[tb][0] || qy > mdl_y[tb][nr-1]) r.status = ST_Y_RANGE;
                else begin
                    ix = bracket_x(tb, nc, qx);
                    iy = bracket_y(tb, nr, qy);
                    lo = lerp_axis(mdl_z[tb][iy][ix], mdl_z[tb][iy][ix+1],
                                   mdl_x[tb][ix], mdl_x[tb][ix+1], qx);
                    hi = lerp_axis(mdl_z[tb][iy+1][ix], mdl_z[tb][iy+1][ix+1],
                                   mdl_x[tb][ix], mdl_x[tb][ix+1], qx);
                    r.value = 32'(lerp_axis(lo, hi, mdl_y[tb][iy], mdl_y[tb][iy+1], qy));
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    task automatic queue_cmd(logic [OP_W-1:0] op, int tb, int col, int row,
                             logic [31:0] data, logic [31:0] qx, logic [31:0] qy,
                             int ncol, int nrow);
        t_cmd c;
        c.op = op; c.tid = tb; c.col = col; c.row = row; c.data = data;
        c.qx = qx; c.qy = qy; c.ncol = ncol; c.nrow = nrow;
        if (op == OP_WR_X) gen_x[tb][col] = longint'($signed(data));
        if (op == OP_WR_Y) gen_y[tb][row] = longint'($signed(data));
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(3))
            0: return $urandom_range(65535) - 32768;
            1: return $urandom;
            default: return $urandom_range(32'h00ffffff) - 32'h00800000;
        endcase
    endfunction

    // rewrites the breakpoints of one axis, sorted unless scrambled
    task automatic load_axis(int tb, bit axis_y, int n, int mode);
        longint v[MAX_POINTS];
        longint tmp;
        for (int i = 0; i < n; i++) v[i] = longint'($signed(rand_value()));
        if (mode != 2)
            for (int i = 1; i < n; i++)
                for (int j = i; j > 0 && v[j-1] > v[j]; j--) begin
                    tmp = v[j]; v[j] = v[j-1]; v[j-1] = tmp;
                end
        if (mode == 1)
            for (int i = 1; i < n; i++)
                if ($urandom_range(2) == 0) v[i] = v[i-1];
        for (int i = 0; i < n; i++)
            if (axis_y) queue_cmd(OP_WR_Y, tb, $urandom, i, v[i], $urandom, $urandom,
                                  $urandom, $urandom);
            else queue_cmd(OP_WR_X, tb, i, $urandom, v[i], $urandom, $urandom,
                           $urandom, $urandom);
    endtask

    task automatic load_cells(int tb, int nc, int nr, bit all_cells);
        for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++)
                if (all_cells || $urandom_range(3) == 0)
                    queue_cmd(OP_WR_Z, tb, c, r, rand_value(), $urandom, $urandom,
                              $urandom, $urandom);
    endtask

    function automatic longint pick_coord(longint lo, longint hi);
        longint unsigned span;
        span = longint'(hi - lo) + 1;
        case ($urandom_range(5))
            0: return lo;
            1: return hi;
            default: return lo + longint'({$urandom, $urandom} % span);
        endcase
    endfunction

    task automatic queue_query(int tb, bit allow_bad);
        longint x0, x1, y0, y1, qx, qy;
        x0 = gen_x[tb][0]; x1 = gen_x[tb][gen_cols[tb]-1];
        y0 = gen_y[tb][0]; y1 = gen_y[tb][gen_rows[tb]-1];
        qx = (x0 <= x1) ? pick_coord(x0, x1) : x0;
        qy = (y0 <= y1) ? pick_coord(y0, y1) : y0;
        if (allow_bad && $urandom_range(9) == 0) begin
            if ($urandom_range(1)) qx = longint'($signed($urandom));
            else qy = longint'($signed($urandom));
        end
        queue_cmd(OP_QUERY, tb, $urandom, $urandom, $urandom, qx, qy, $urandom, $urandom);
    endtask

    task automatic setup_table(int tb, int nc, int nr);
        gen_cols[tb] = nc;
        gen_rows[tb] = nr;
        load_axis(tb, 0, MAX_POINTS, 0);
        load_axis(tb, 1, MAX_POINTS, 0);
        load_axis(tb, 0, nc, 0);
        load_axis(tb, 1, nr, 0);
        load_cells(tb, nc, nr, 1);
    endtask

    // stimulus
    initial begin
        int tb, n;
        // directed: uncommitted query, bad sizes, unused ops, extreme values, a repeated commit
        queue_cmd(OP_QUERY, 3, 0, 0, 0, 0, 0, 0, 0);
        queue_cmd(OP_COMMIT, 0, 0, 0, 0, 0, 0, 1, 2);
        queue_cmd(OP_COMMIT, 0, 0, 0, 0, 0, 0, 2, 17);
        queue_cmd(OP_COMMIT, 0, 0, 0, 0, 0, 0, 0, 31);
        for (int k = 5; k < 8; k++)
            queue_cmd(k, k & 3, 15, 15, 32'hffffffff, 32'hffffffff, 32'hffffffff, 31, 31);
        queue_cmd(OP_WR_X, 0, 0, 0, 32'h80000000, 0, 0, 0, 0);
        queue_cmd(OP_WR_X, 0, 1, 0, 32'h7fffffff, 0, 0, 0, 0);
        queue_cmd(OP_WR_Y, 0, 0, 0, 32'h80000000, 0, 0, 0, 0);
        queue_cmd(OP_WR_Y, 0, 0, 1, 32'h7fffffff, 0, 0, 0, 0);
        queue_cmd(OP_WR_Z, 0, 0, 0, 32'h80000000, 0, 0, 0, 0);
        queue_cmd(OP_WR_Z, 0, 1, 0, 32'h7fffffff, 0, 0, 0, 0);
        queue_cmd(OP_WR_Z, 0, 0, 1, 32'h7fffffff, 0, 0, 0, 0);
        queue_cmd(OP_WR_Z, 0, 1, 1, 32'h80000000, 0, 0, 0, 0);
        queue_cmd(OP_COMMIT, 0, 0, 0, 0, 0, 0, 2, 2);
        gen_cols[0] = 2; gen_rows[0] = 2;
        queue_cmd(OP_COMMIT, 0, 0, 0, 0, 0, 0, 3, 3);
        queue_cmd(OP_QUERY, 0, 0, 0, 0, 32'h80000000, 32'h80000000, 0, 0);
        queue_cmd(OP_QUERY, 0, 0, 0, 0, 32'h7fffffff, 32'h7fffffff, 0, 0);
        queue_cmd(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0);
        // remaining tables, the largest size among them
        setup_table(1, MAX_POINTS, MAX_POINTS);
        queue_cmd(OP_COMMIT, 1, 0, 0, 0, 0, 0, MAX_POINTS, MAX_POINTS);
        setup_table(2, $urandom_range(2, 5), $urandom_range(2, 5));
        queue_cmd(OP_COMMIT, 2, 0, 0, 0, 0, 0, gen_cols[2], gen_rows[2]);
        setup_table(3, 3, 2);
        queue_cmd(OP_COMMIT, 3, 0, 0, 0, 0, 0, 3, 2);
        // random: content rewrites, stray ops and bursts of queries in random order
        while (pending_cmds.size() < 1600) begin
            tb = $urandom_range(3);
            case ($urandom_range(9))
                0: load_axis(tb, 0, gen_cols[tb], $urandom_range(2));
                1: load_axis(tb, 1, gen_rows[tb], $urandom_range(2));
                2: begin
                    load_axis(tb, 0, gen_cols[tb], 0);
                    load_axis(tb, 1, gen_rows[tb], 0);
                end
                3: if (gen_cols[tb] * gen_rows[tb] <= 25) load_cells(tb, gen_cols[tb],
                                                                     gen_rows[tb], 0);
                4: queue_cmd($urandom_range(3, 7), tb, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom);
                5: queue_cmd(OP_WR_Z, tb, $urandom, $urandom, rand_value(), $urandom,
                             $urandom, $urandom, $urandom);
                default: begin
                    n = $urandom_range(1, 6);
                    for (int k = 0; k < n; k++) queue_query(tb, 1);
                end
            endcase
        end
        stim_done = 1;
    end

    // reset and cycle count
    initial begin
        i_rst_n = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end else if (!s_axis_tvalid || in_accepted) begin
            if (pending_cmds.size() > 0 && (($urandom_range(99) >= 27) ||
                (cycle_count > 20000 && cycle_count < 60000))) begin
                s_axis_tvalid <= 1;
                s_axis_tuser  <= pending_cmds[0].op;
                s_axis_tdata  <= {4'b0, pending_cmds[0].nrow, pending_cmds[0].ncol,
                                  pending_cmds[0].qy, pending_cmds[0].qx,
                                  pending_cmds[0].data, pending_cmds[0].row,
                                  pending_cmds[0].col, pending_cmds[0].tid};
            end else begin
                s_axis_tvalid <= 0;
            end
        end
    end

    // long receiver hold-off
    always @(negedge i_clk) begin
        if (cycle_count == 8000) hold_cycles <= 800;
        else if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 0;
        else m_axis_tready <= (hold_cycles == 0) &&
             (($urandom_range(99) >= 27) || (cycle_count > 20000 && cycle_count < 60000));
    end

    // monitor
    always @(posedge i_clk) begin
        t_res want;
        in_accepted = 0;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            expected_results.insert(expected_results.size(),
                                    apply_cmd(pending_cmds.pop_front()));
            in_accepted = 1;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata, 0);
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", m_axis_tuser, want.status);
                if (m_axis_tdata !== want.value)
                    report_mismatch("value", m_axis_tdata, want.value);
            end
        end
    end

    // end of run
    initial begin
        wait (stim_done);
        wait (pending_cmds.size() == 0 && expected_results.size() == 0);
        repeat (500) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
